[sv/blie_pkg.sv]
// Shared types and codes of the bounded indexed list engine.
package blie_pkg;

  localparam int MAX_ENTRIES = 64;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_READ       = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] data_value;
  } blie_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
  } blie_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } blie_state_t;

endpackage

[sv/blie_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module blie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bounded_indexed_list_engine.sv]
// Top level of the bounded indexed list engine: sequencer, count and result register.
//
//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------
//  in_     | input     | opcode, position, data_value (blie_in_t)
//  out_    | output    | read_value, status, entry_count, flags (blie_out_t)
//  cfg_    | input     | capacity, always accepted
//
// A failing or unknown item goes straight to the result; a read first fetches its entry.
// An insert at p into a list of n entries moves entries p..n-1 up one place, then writes
// the value; a delete at p moves entries p+1..n-1 down one place. Each moved entry costs
// one RAM read and one RAM write through the single entry store, whose read data is registered.
// Reset clears the count, the sequencer and the result valid flag; the entry store is
// not cleared. A stalled result holds the sequencer until out_ready takes the beat.
module bounded_indexed_list_engine #(
  parameter int VALUE_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  blie_pkg::blie_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output blie_pkg::blie_out_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [blie_pkg::CAP_W-1:0]  cfg_data
);

  import blie_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int MW     = ($clog2(MAX_ENTRIES + 1) > CAP_W) ? $clog2(MAX_ENTRIES + 1) : CAP_W;

  // Sequencer state and working registers.
  blie_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic                 is_del_r, is_del_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [DATA_W-1:0]    rv_r, rv_nxt;
  logic [CAP_W-1:0]     capacity_r;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  blie_out_t            out_data_r, out_data_nxt;

  // Entry store ports.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [VALUE_BITS-1:0] ram_rdata;

  // Capacity above the store depth is clipped to the depth.
  logic [MW-1:0]        cap_ext;
  logic [MW-1:0]        max_ext;
  logic [CNT_W-1:0]     eff_cap;
  logic                 full;
  logic [CNT_W-1:0]     in_pos;
  logic                 accept;
  logic                 last_move;

  assign cap_ext = MW'(capacity_r);
  assign max_ext = MW'(MAX_ENTRIES);
  assign eff_cap = (cap_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(cap_ext);
  assign full    = (count_r >= eff_cap);
  assign in_pos  = CNT_W'(in_data.position);
  assign accept  = in_valid && in_ready;

  // An insert walks from the tail down to the insert position; a delete walks from just
  // past the deleted position up to the tail.
  assign last_move = is_del_r ? (idx_r == count_r - CNT_W'(1)) : (idx_r == pos_r);

  blie_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state and working registers.
  always_comb begin
    logic       do_place;
    logic [CNT_W-1:0] place_pos;
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    is_del_nxt    = is_del_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    do_place      = 1'b0;
    place_pos     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = VALUE_BITS'(in_data.data_value);
          pos_nxt    = in_pos;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_data.opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                do_place  = 1'b1;
                place_pos = '0;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                do_place  = 1'b1;
                place_pos = count_r;
              end
            end
            OP_INSERT: begin
              if (in_pos == '0) begin
                if (full) begin
                  status_nxt = ST_FULL;
                end else begin
                  do_place  = 1'b1;
                  place_pos = '0;
                end
              end else if (in_pos >= count_r) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                do_place  = 1'b1;
                place_pos = in_pos;
              end
            end
            OP_READ: begin
              if (in_pos >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                state_nxt = S_FETCH;
              end
            end
            OP_DELETE: begin
              if (in_pos >= count_r) begin
                status_nxt = ST_RANGE;
              end else if (in_pos + CNT_W'(1) < count_r) begin
                is_del_nxt = 1'b1;
                idx_nxt    = in_pos + CNT_W'(1);
                state_nxt  = S_RD;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase

          if (do_place) begin
            pos_nxt    = place_pos;
            is_del_nxt = 1'b0;
            if (count_r > place_pos) begin
              idx_nxt   = count_r - CNT_W'(1);
              state_nxt = S_RD;
            end else begin
              state_nxt = S_PUT;
            end
          end

          rv_nxt = (status_nxt != ST_OK) ? '1 : '0;
        end
      end
      S_FETCH: begin
        rv_nxt    = DATA_W'($signed(ram_rdata));
        state_nxt = S_DONE;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (last_move) begin
          if (is_del_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          idx_nxt   = is_del_r ? idx_r + CNT_W'(1) : idx_r - CNT_W'(1);
          state_nxt = S_RD;
        end
      end
      S_PUT: begin
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.read_value  = rv_r;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = count_r;
          out_data_nxt.is_empty    = (count_r == '0);
          out_data_nxt.is_full     = full;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake and entry store controls.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    cfg_ready = 1'b1;
    ram_we    = 1'b0;
    ram_raddr = ADDR_W'(idx_r);
    ram_waddr = ADDR_W'(pos_r);
    ram_wdata = val_r;
    case (state_r)
      S_IDLE: begin
        // A read looks up its entry while the item is being accepted.
        ram_raddr = ADDR_W'(in_pos);
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = is_del_r ? ADDR_W'(idx_r - CNT_W'(1)) : ADDR_W'(idx_r + CNT_W'(1));
        ram_wdata = ram_rdata;
      end
      S_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= CAP_W'(64);
      out_valid_r <= 1'b0;
      is_del_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      is_del_r    <= is_del_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    rv_r       <= rv_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
